// File: src/ps2mc_pkg.sv
// ps2mc_pkg: types and constants shared by the ps/2 mouse packet decoder
// no dependencies; compiled first
`default_nettype none

package ps2mc_pkg;

  localparam int unsigned COORD_WIDTH = 12;
  localparam int unsigned BYTE_WIDTH  = 8;
  localparam int unsigned BTN_WIDTH   = 3;
  localparam int unsigned SEQ_WIDTH   = 32;
  localparam int unsigned PDATA_WIDTH = 32;
  localparam int unsigned PADDR_WIDTH = 3;

  // flags byte layout
  localparam int unsigned SYNC_BIT   = 3;
  localparam int unsigned X_SIGN_BIT = 4;
  localparam int unsigned Y_SIGN_BIT = 5;
  localparam logic [BYTE_WIDTH-1:0] OVF_MASK = 8'hC0;

  // register indexes
  localparam logic REG_MAX_X = 1'b0;
  localparam logic REG_MAX_Y = 1'b1;

  localparam logic [COORD_WIDTH-1:0] MAX_X_RESET = COORD_WIDTH'(1023);
  localparam logic [COORD_WIDTH-1:0] MAX_Y_RESET = COORD_WIDTH'(767);

  typedef logic [COORD_WIDTH-1:0] coord_t;
  typedef logic [BYTE_WIDTH-1:0]  byte_t;

  typedef enum logic [1:0] {
    POS_FLAGS = 2'd0,
    POS_X     = 2'd1,
    POS_Y     = 2'd2
  } byte_pos_e;

  // operands of one cursor update
  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t max_x;
    coord_t max_y;
    byte_t  flags;
    byte_t  x_byte;
    byte_t  y_byte;
  } upd_req_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
  } upd_res_t;

endpackage

`default_nettype wire

// File: src/ps2mc_byte_if.sv
// ps2mc_byte_if: valid/ready channel carrying one mouse byte
// depends on ps2mc_pkg
`default_nettype none

interface ps2mc_byte_if;
  logic               valid;
  logic               ready;
  ps2mc_pkg::byte_t   data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// File: src/ps2mc_pos_if.sv
// ps2mc_pos_if: valid/ready channel carrying one cursor report
// depends on ps2mc_pkg
`default_nettype none

interface ps2mc_pos_if;
  logic                                 valid;
  logic                                 ready;
  ps2mc_pkg::coord_t                    cursor_x;
  ps2mc_pkg::coord_t                    cursor_y;
  logic [ps2mc_pkg::BTN_WIDTH-1:0]      buttons;
  logic [ps2mc_pkg::SEQ_WIDTH-1:0]      sequence_res;

  modport source (output valid, output cursor_x, output cursor_y, output buttons,
                  output sequence_res, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input buttons,
                  input sequence_res, output ready);
endinterface

`default_nettype wire

// File: src/ps2mc_update.sv
// ps2mc_update: forms the 9-bit deltas and the clamped new cursor position
// depends on ps2mc_pkg
`default_nettype none

module ps2mc_update (
  input  ps2mc_pkg::upd_req_t req_i,
  output ps2mc_pkg::upd_res_t res_o
);

  localparam int unsigned CW = ps2mc_pkg::COORD_WIDTH;
  localparam int unsigned SW = CW + 2;

  logic [8:0]          dx;
  logic [8:0]          dy;
  logic signed [SW-1:0] sum_x;
  logic signed [SW-1:0] sum_y;

  assign dx = {req_i.flags[ps2mc_pkg::X_SIGN_BIT], req_i.x_byte};
  assign dy = {req_i.flags[ps2mc_pkg::Y_SIGN_BIT], req_i.y_byte};

  // x moves right with dx, screen y moves down against dy
  assign sum_x = $signed({2'b00, req_i.pos_x}) + $signed({{(SW-9){dx[8]}}, dx});
  assign sum_y = $signed({2'b00, req_i.pos_y}) - $signed({{(SW-9){dy[8]}}, dy});

  always_comb begin
    if (sum_x[SW-1]) begin
      res_o.pos_x = '0;
    end else if (sum_x[SW-2:0] > {1'b0, req_i.max_x}) begin
      res_o.pos_x = req_i.max_x;
    end else begin
      res_o.pos_x = sum_x[CW-1:0];
    end

    if (sum_y[SW-1]) begin
      res_o.pos_y = '0;
    end else if (sum_y[SW-2:0] > {1'b0, req_i.max_y}) begin
      res_o.pos_y = req_i.max_y;
    end else begin
      res_o.pos_y = sum_y[CW-1:0];
    end
  end

endmodule

`default_nettype wire

// File: src/ps2_mouse_packet_cursor.sv
// One byte is taken per clock unless input stalls. A byte goes into an input register
// and is decoded from there, when it updates the framing state; the third byte of a
// packet without overflow updates the cursor and loads the report register, so a
// report passes through the input and report registers. The report register frees the
// input side: bytes keep flowing while a report waits, and input stalls only when
// a new report is due while the previous one has not been taken. max_x and max_y
// (APB at 0x0 and 0x4) are to be written while no packet is in flight.
// depends on ps2mc_pkg, ps2mc_byte_if, ps2mc_pos_if, ps2mc_update
`default_nettype none

module ps2_mouse_packet_cursor (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  ps2mc_byte_if.sink                                in_bus,
  ps2mc_pos_if.source                               out_bus,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [ps2mc_pkg::PADDR_WIDTH-1:0]    paddr,
  input  wire logic [ps2mc_pkg::PDATA_WIDTH-1:0]    pwdata,
  output logic      [ps2mc_pkg::PDATA_WIDTH-1:0]    prdata,
  output logic                                      pready
);

  localparam int unsigned CW = ps2mc_pkg::COORD_WIDTH;

  ps2mc_pkg::coord_t max_x_q, max_y_q;
  logic              reg_sel;
  logic              cfg_we;

  logic              s1_valid_q;
  ps2mc_pkg::byte_t  s1_byte_q;
  logic              s1_go;
  logic              emit;

  ps2mc_pkg::byte_pos_e bpos_q, bpos_d;
  logic                 flags_we, xbyte_we;
  ps2mc_pkg::byte_t     flags_q, xbyte_q;

  ps2mc_pkg::coord_t                 pos_x_q, pos_y_q;
  logic [ps2mc_pkg::BTN_WIDTH-1:0]   btn_q;
  logic [ps2mc_pkg::SEQ_WIDTH-1:0]   count_q;
  logic                              out_valid_q;

  ps2mc_pkg::upd_req_t upd_req;
  ps2mc_pkg::upd_res_t upd_res;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_we  = psel && penable && pwrite;
  assign prdata  = (reg_sel == ps2mc_pkg::REG_MAX_Y)
                 ? ps2mc_pkg::PDATA_WIDTH'(max_y_q)
                 : ps2mc_pkg::PDATA_WIDTH'(max_x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q <= ps2mc_pkg::MAX_X_RESET;
      max_y_q <= ps2mc_pkg::MAX_Y_RESET;
    end else if (cfg_we) begin
      if (reg_sel == ps2mc_pkg::REG_MAX_Y) begin
        max_y_q <= pwdata[CW-1:0];
      end else begin
        max_x_q <= pwdata[CW-1:0];
      end
    end
  end

  // input register
  assign emit  = s1_valid_q && (bpos_q == ps2mc_pkg::POS_Y)
              && ((flags_q & ps2mc_pkg::OVF_MASK) == '0);
  assign s1_go = s1_valid_q && (!emit || !out_valid_q || out_bus.ready);
  assign in_bus.ready = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_q <= in_bus.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_byte_q <= in_bus.data_byte;
    end
  end

  // packet framing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpos_q <= ps2mc_pkg::POS_FLAGS;
    end else begin
      bpos_q <= bpos_d;
    end
  end

  always_comb begin
    bpos_d   = bpos_q;
    flags_we = 1'b0;
    xbyte_we = 1'b0;
    if (s1_go) begin
      case (bpos_q)
        ps2mc_pkg::POS_X: begin
          xbyte_we = 1'b1;
          bpos_d   = ps2mc_pkg::POS_Y;
        end
        ps2mc_pkg::POS_Y: begin
          bpos_d = ps2mc_pkg::POS_FLAGS;
        end
        default: begin
          // first byte must carry the sync bit, else drop it
          if (s1_byte_q[ps2mc_pkg::SYNC_BIT]) begin
            flags_we = 1'b1;
            bpos_d   = ps2mc_pkg::POS_X;
          end else begin
            bpos_d = ps2mc_pkg::POS_FLAGS;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (flags_we) begin
      flags_q <= s1_byte_q;
    end
    if (xbyte_we) begin
      xbyte_q <= s1_byte_q;
    end
  end

  // cursor update
  assign upd_req.pos_x  = pos_x_q;
  assign upd_req.pos_y  = pos_y_q;
  assign upd_req.max_x  = max_x_q;
  assign upd_req.max_y  = max_y_q;
  assign upd_req.flags  = flags_q;
  assign upd_req.x_byte = xbyte_q;
  assign upd_req.y_byte = s1_byte_q;

  ps2mc_update u_update (
    .req_i (upd_req),
    .res_o (upd_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      btn_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_go && emit) begin
        pos_x_q     <= upd_res.pos_x;
        pos_y_q     <= upd_res.pos_y;
        btn_q       <= flags_q[ps2mc_pkg::BTN_WIDTH-1:0];
        count_q     <= count_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_bus.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_bus.valid        = out_valid_q;
  assign out_bus.cursor_x     = pos_x_q;
  assign out_bus.cursor_y     = pos_y_q;
  assign out_bus.buttons      = btn_q;
  assign out_bus.sequence_res = count_q;

`ifndef SYNTHESIS
  // a report is only loaded by the last byte of a packet
  a_emit_on_third: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(bpos_q) == ps2mc_pkg::POS_Y)
    else $error("report loaded outside the third byte");

  // the packet counter moves only with a report
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_go && emit) |=> $stable(count_q))
    else $error("packet counter changed without a report");

  // an updated cursor never exceeds the bounds in force
  a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && emit) |=> (pos_x_q <= $past(max_x_q)) && (pos_y_q <= $past(max_y_q)))
    else $error("cursor beyond bounds");

  // a pending report is never overwritten
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_bus.ready) |-> !(s1_go && emit))
    else $error("report overwritten while pending");
`endif

endmodule

`default_nettype wire

// File: tb/tb.sv
// tb: self-checking bench for ps2_mouse_packet_cursor, byte stream in, cursor reports out
// depends on ps2mc_pkg, ps2mc_byte_if, ps2mc_pos_if and the rtl of the decoder
`timescale 1ns / 100ps

module tb;
  import ps2mc_pkg::*;

  typedef struct packed {
    coord_t                 cur_x;
    coord_t                 cur_y;
    logic [BTN_WIDTH-1:0]   btn;
    logic [SEQ_WIDTH-1:0]   seq;
  } cursor_report_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [PADDR_WIDTH-1:0] paddr   = '0;
  logic [PDATA_WIDTH-1:0] pwdata  = '0;
  logic [PDATA_WIDTH-1:0] prdata;
  logic                   pready;

  ps2mc_byte_if byte_bus ();
  ps2mc_pos_if  pos_bus ();

  ps2_mouse_packet_cursor i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_bus  (byte_bus),
    .out_bus (pos_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // stimulus and expectations
  byte_t          pending_bytes[$];
  cursor_report_t expected_reports[$];
  int             send_idle_pct = 0;
  int             stall_pct     = 0;
  logic           hold_bytes    = 1'b0;
  int             err_cnt       = 0;

  // decoder mirror
  byte_pos_e frame_pos = POS_FLAGS;
  byte_t     flags_q, xbyte_q;
  coord_t    cur_x = '0, cur_y = '0;
  coord_t    lim_x = MAX_X_RESET, lim_y = MAX_Y_RESET;
  logic [BTN_WIDTH-1:0] btn_q = '0;
  logic [SEQ_WIDTH-1:0] pkt_cnt = '0;

  int bytes_sent = 0, reports_seen = 0, ovf_drops = 0, unsync_drops = 0;

  function automatic int clamp_to(int v, coord_t hi);
    if (v < 0) v = 0;
    if (v > int'(hi)) v = int'(hi);
    return v;
  endfunction

  task automatic track_mouse_byte(byte_t b);
    int dx, dy;
    bytes_sent++;
    case (frame_pos)
      POS_X: begin
        xbyte_q   = b;
        frame_pos = POS_Y;
      end
      POS_Y: begin
        frame_pos = POS_FLAGS;
        if ((flags_q & OVF_MASK) != '0) begin
          ovf_drops++;
        end else begin
          dx      = int'(xbyte_q) - (flags_q[X_SIGN_BIT] ? 256 : 0);
          dy      = int'(b) - (flags_q[Y_SIGN_BIT] ? 256 : 0);
          cur_x   = coord_t'(clamp_to(int'(cur_x) + dx, lim_x));
          cur_y   = coord_t'(clamp_to(int'(cur_y) - dy, lim_y));
          btn_q   = flags_q[BTN_WIDTH-1:0];
          pkt_cnt = pkt_cnt + 1'b1;
          expected_reports.push_back('{cur_x, cur_y, btn_q, pkt_cnt});
        end
      end
      default: begin
        if (!b[SYNC_BIT]) begin
          frame_pos = POS_FLAGS;
          unsync_drops++;
        end else begin
          flags_q   = b;
          frame_pos = POS_X;
        end
      end
    endcase
  endtask

  // byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_bus.valid     <= 1'b0;
      byte_bus.data_byte <= '0;
    end else if (!byte_bus.valid || byte_bus.ready) begin
      if (byte_bus.valid) track_mouse_byte(byte_bus.data_byte);
      if (pending_bytes.size() > 0 && !hold_bytes &&
          $urandom_range(99) >= send_idle_pct) begin
        byte_bus.valid     <= 1'b1;
        byte_bus.data_byte <= pending_bytes.pop_front();
      end else begin
        byte_bus.valid <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v, logic bad);
    if (bad) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // report monitor
  always @(posedge clk_i or negedge rst_ni) begin
    cursor_report_t exp_r;
    if (!rst_ni) begin
      pos_bus.ready <= 1'b0;
    end else begin
      if (pos_bus.valid && pos_bus.ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report x=%0d y=%0d buttons=%0d seq=%0d", $time,
                   pos_bus.cursor_x, pos_bus.cursor_y, pos_bus.buttons,
                   pos_bus.sequence_res);
          err_cnt++;
        end else begin
          exp_r = expected_reports.pop_front();
          reports_seen++;
          check_field("cursor_x", exp_r.cur_x, pos_bus.cursor_x,
                      pos_bus.cursor_x !== exp_r.cur_x);
          check_field("cursor_y", exp_r.cur_y, pos_bus.cursor_y,
                      pos_bus.cursor_y !== exp_r.cur_y);
          check_field("buttons", exp_r.btn, pos_bus.buttons,
                      pos_bus.buttons !== exp_r.btn);
          check_field("sequence_res", exp_r.seq, pos_bus.sequence_res,
                      pos_bus.sequence_res !== exp_r.seq);
        end
      end
      pos_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || byte_bus.valid || expected_reports.size() != 0)
      @(posedge clk_i);
    // a dropped packet leaves no report behind, give the pipeline time to empty
    repeat (8) @(posedge clk_i);
  endtask

  // bring framing back to the flags byte so no packet is in flight
  task automatic settle_frame();
    wait_drained();
    while (frame_pos != POS_FLAGS) begin
      pending_bytes.push_back(8'h00);
      wait_drained();
    end
  endtask

  task automatic write_bound(logic idx, logic [PDATA_WIDTH-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MAX_X) lim_x = value[COORD_WIDTH-1:0];
    else                  lim_y = value[COORD_WIDTH-1:0];
  endtask

  // mostly well-formed packets; drift_pct pulls the cursor right and down
  task automatic push_packets(int n, int drift_pct);
    byte_t f;
    int    r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        pending_bytes.push_back(byte_t'($urandom));
      end else if (r < 13) begin
        // truncated packet, framing shifts onto the next bytes
        f = byte_t'($urandom);
        f[SYNC_BIT] = 1'b1;
        pending_bytes.push_back(f);
        if ($urandom_range(1)) pending_bytes.push_back(byte_t'($urandom));
      end else begin
        f = byte_t'($urandom);
        f[SYNC_BIT] = 1'b1;
        if ($urandom_range(9) != 0) f = f & ~OVF_MASK;
        if ($urandom_range(99) < drift_pct) begin
          f[X_SIGN_BIT] = 1'b0;
          f[Y_SIGN_BIT] = 1'b1;
        end
        pending_bytes.push_back(f);
        pending_bytes.push_back(byte_t'($urandom));
        pending_bytes.push_back(byte_t'($urandom));
      end
    end
  endtask

  initial begin
    byte_t directed[$];
    byte_bus.valid     = 1'b0;
    byte_bus.data_byte = '0;
    pos_bus.ready      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset bounds, no idling; unsynced bytes, sign and overflow corners
    directed = '{8'h00, 8'hF7,
                 8'h08, 8'hFF, 8'h00,
                 8'h18, 8'h00, 8'hFF,
                 8'h2F, 8'h7F, 8'h01,
                 8'hC8, 8'h55, 8'hAA,
                 8'h48, 8'h01, 8'h01,
                 8'h8F, 8'h02, 8'h02,
                 8'h3F, 8'h80, 8'h80};
    foreach (directed[i]) pending_bytes.push_back(directed[i]);
    push_packets(100, 0);
    settle_frame();

    // widest bounds, upper bits ignored; sender idles
    write_bound(REG_MAX_X, 32'hFFFF_FFFF);
    write_bound(REG_MAX_Y, 32'h0000_0FFF);
    send_idle_pct = 52;
    push_packets(50, 75);
    wait_drained();
    hold_bytes = 1'b1;
    while (expected_reports.size() != 0) @(posedge clk_i);
    hold_bytes = 1'b0;
    push_packets(70, 75);
    settle_frame();

    // bounds pinned to zero, below the cursor; receiver stalls
    write_bound(REG_MAX_X, 32'h0000_0000);
    write_bound(REG_MAX_Y, 32'hABCD_E000);
    send_idle_pct = 0;
    stall_pct     = 52;
    push_packets(60, 50);
    settle_frame();

    // small bounds; both sides idle
    write_bound(REG_MAX_X, 32'd300);
    write_bound(REG_MAX_Y, 32'd200);
    send_idle_pct = 13;
    stall_pct     = 13;
    push_packets(100, 60);
    settle_frame();

    // random bounds, no idling
    write_bound(REG_MAX_X, $urandom);
    write_bound(REG_MAX_Y, $urandom);
    send_idle_pct = 0;
    stall_pct     = 0;
    push_packets(120, 40);
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (expected_reports.size() != 0) begin
      $display("%0t: %0d reports never arrived", $time, expected_reports.size());
      err_cnt++;
    end
    $display("covered %0d bytes over 5 bound settings: %0d reports checked,", bytes_sent,
             reports_seen);
    $display("%0d overflow packets and %0d unsynced bytes dropped, %0d errors", ovf_drops,
             unsync_drops, err_cnt);
    if (err_cnt == 0) begin
      $display("ps2_mouse_packet_cursor verification clean");
    end else begin
      $display("ps2_mouse_packet_cursor verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("ps2_mouse_packet_cursor verification failed");
    $finish;
  end

endmodule
